// ----- rtl/scsa_pkg.sv -----
// Shared types and constants for the size-class slot allocator.
// Holds the command record that travels from classifier to executor.
// No dependencies.
package scsa_pkg;

    // Field widths of the stream payloads.
    localparam int LG_W           = 4;
    localparam int BYTES_W        = 13;
    localparam int OFFSET_W       = 20;
    localparam int STATUS_W       = 3;
    localparam int S_TDATA_W      = 40;
    localparam int M_TDATA_W      = 24;

    // Pool address space in bits; a slot may not end past 2**POOL_ADDR_BITS.
    localparam int POOL_ADDR_BITS = 20;

    // Sized for up to 8 classes of up to 64 slots of up to 4 KiB each.
    localparam int CLS_W          = 3;
    localparam int IDX_W          = 6;
    localparam int SUM_W          = 22;

    // Size registers.
    localparam int NUM_REGS       = 4;
    localparam int REG_IDX_W      = 2;
    localparam logic [LG_W-1:0] MAX_LG = 4'd12;
    localparam logic [LG_W-1:0] CFG_RESET [NUM_REGS] = '{4'd3, 4'd5, 4'd7, 4'd9};

    typedef enum logic [STATUS_W-1:0] {
        ST_OK             = 3'd0,
        ST_NO_SPACE       = 3'd1,
        ST_TOO_LARGE      = 3'd2,
        ST_BAD_ADDRESS    = 3'd3,
        ST_DOUBLE_OR_ZERO = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        CMD_ALLOC  = 2'd0,
        CMD_FREE   = 2'd1,
        CMD_REPORT = 2'd2
    } cmd_kind_t;

    typedef enum logic {
        ACT_ALLOC = 1'b0,
        ACT_FREE  = 1'b1
    } action_t;

    // One classified request.
    typedef struct packed {
        cmd_kind_t              kind;
        status_t                status;  // used by CMD_REPORT only
        logic [CLS_W-1:0]       cls;
        logic [LG_W-1:0]        lg;
        logic [IDX_W-1:0]       idx;     // slot to release
        logic [SUM_W-1:0]       base;    // class base offset
    } cmd_t;

endpackage

// ----- rtl/scsa_front.sv -----
// Classifier: picks the size class for an allocate and locates the slot for a free.
// Depends on scsa_pkg; purely combinational, its result is pushed into the queue.
module scsa_front
    import scsa_pkg::*;
#(
    parameter int NUM_CLASSES     = 4,
    parameter int SLOTS_PER_CLASS = 64
) (
    input  logic                action,
    input  logic [BYTES_W-1:0]  request_bytes,
    input  logic [OFFSET_W-1:0] release_offset,
    input  logic [LG_W-1:0]     class_lg [NUM_CLASSES],
    output cmd_t                cmd
);

    logic [SUM_W-1:0] bases [NUM_CLASSES];
    logic [SUM_W-1:0] spans [NUM_CLASSES];

    // Class bases lie back to back in class order.
    always_comb begin
        logic [SUM_W-1:0] acc;
        acc = '0;
        for (int c = 0; c < NUM_CLASSES; c++) begin
            bases[c] = acc;
            spans[c] = SUM_W'(SLOTS_PER_CLASS) << class_lg[c];
            acc      = acc + spans[c];
        end
    end

    // Classification of the request.
    always_comb begin
        logic             found;
        logic [SUM_W-1:0] addr_ext;
        logic [SUM_W-1:0] diff;
        found    = 1'b0;
        addr_ext = SUM_W'(release_offset);
        diff     = '0;
        cmd      = '{kind: CMD_REPORT, status: ST_OK, cls: '0, lg: '0, idx: '0, base: '0};
        if (action == ACT_ALLOC) begin
            // First class whose slot size holds the byte count.
            for (int c = 0; c < NUM_CLASSES; c++) begin
                if (!found && (request_bytes <= (BYTES_W'(1) << class_lg[c]))) begin
                    found    = 1'b1;
                    cmd.cls  = CLS_W'(c);
                    cmd.lg   = class_lg[c];
                    cmd.base = bases[c];
                end
            end
            if (request_bytes == '0) begin
                cmd.kind   = CMD_REPORT;
                cmd.status = ST_DOUBLE_OR_ZERO;
            end else if (!found) begin
                cmd.kind   = CMD_REPORT;
                cmd.status = ST_TOO_LARGE;
            end else begin
                cmd.kind   = CMD_ALLOC;
            end
        end else begin
            // First class whose slot range contains the offset.
            for (int c = 0; c < NUM_CLASSES; c++) begin
                if (!found && (addr_ext >= bases[c]) &&
                    (addr_ext < bases[c] + spans[c])) begin
                    found   = 1'b1;
                    diff    = (addr_ext - bases[c]) >> class_lg[c];
                    cmd.cls = CLS_W'(c);
                    cmd.lg  = class_lg[c];
                    cmd.idx = diff[IDX_W-1:0];
                end
            end
            if (found) begin
                cmd.kind   = CMD_FREE;
            end else begin
                cmd.kind   = CMD_REPORT;
                cmd.status = ST_BAD_ADDRESS;
            end
        end
    end

endmodule

// ----- rtl/scsa_cmd_fifo.sv -----
// Two-entry command queue between the classifier and the executor.
// Depends on scsa_pkg for the command record.
module scsa_cmd_fifo
    import scsa_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic can_push,
    input  logic pop,
    output cmd_t pop_cmd,
    output logic can_pop
);

    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg,  count_next;
    cmd_t       entry_reg [2];

    assign can_push = (count_reg != 2'd2);
    assign can_pop  = (count_reg != 2'd0);
    assign pop_cmd  = entry_reg[rd_ptr_reg];

    // Pointer and fill-count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (pop) begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- rtl/scsa_back.sv -----
// Executor: owns the occupancy maps, claims or releases slots, registers the result.
// Depends on scsa_pkg for the command record and status codes.
module scsa_back
    import scsa_pkg::*;
#(
    parameter int NUM_CLASSES     = 4,
    parameter int SLOTS_PER_CLASS = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cmd_valid,
    input  cmd_t                cmd,
    output logic                cmd_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [OFFSET_W-1:0] out_offset,
    output logic [STATUS_W-1:0] out_status,
    output logic                out_busy
);

    localparam logic [SUM_W-1:0] POOL_LIMIT = SUM_W'(1) << POOL_ADDR_BITS;

    logic [SLOTS_PER_CLASS-1:0] map_reg  [NUM_CLASSES];
    logic [SLOTS_PER_CLASS-1:0] map_next [NUM_CLASSES];

    logic                out_valid_reg, out_valid_next;
    logic [OFFSET_W-1:0] offset_reg,    offset_next;
    status_t             status_reg,    status_next;
    logic                busy_reg,      busy_next;

    // A command executes when the output register is free or being drained.
    assign cmd_pop = cmd_valid && (!out_valid_reg || out_ready);

    // Slot search and map update.
    always_comb begin
        logic [SLOTS_PER_CLASS-1:0] sel_map;
        logic [SLOTS_PER_CLASS-1:0] slot_mask;
        logic [SLOTS_PER_CLASS-1:0] claim_mask;
        logic [IDX_W-1:0]           pos;
        logic                       free_found;
        logic [SUM_W-1:0]           off;
        logic [SUM_W-1:0]           slot_end;
        sel_map    = '0;
        slot_mask  = '0;
        claim_mask = '0;
        pos        = '0;
        free_found = 1'b0;
        for (int c = 0; c < NUM_CLASSES; c++) begin
            map_next[c] = map_reg[c];
            if (cmd.cls == CLS_W'(c)) begin
                sel_map = map_reg[c];
            end
        end
        // Lowest free slot of the chosen class.
        for (int i = SLOTS_PER_CLASS - 1; i >= 0; i--) begin
            if (!sel_map[i]) begin
                free_found = 1'b1;
                pos        = IDX_W'(i);
            end
            slot_mask[i] = (cmd.idx == IDX_W'(i));
        end
        // One-hot mask of the slot to claim, built once the lowest free slot is known.
        for (int i = 0; i < SLOTS_PER_CLASS; i++) begin
            claim_mask[i] = (pos == IDX_W'(i));
        end
        off      = cmd.base + (SUM_W'(pos) << cmd.lg);
        slot_end = off + (SUM_W'(1) << cmd.lg);

        offset_next = offset_reg;
        status_next = status_reg;
        if (cmd_pop) begin
            offset_next = '0;
            case (cmd.kind)
                CMD_ALLOC: begin
                    if (!free_found || (slot_end > POOL_LIMIT)) begin
                        status_next = ST_NO_SPACE;
                    end else begin
                        status_next = ST_OK;
                        offset_next = off[OFFSET_W-1:0];
                        for (int c = 0; c < NUM_CLASSES; c++) begin
                            if (cmd.cls == CLS_W'(c)) begin
                                map_next[c] = map_reg[c] | claim_mask;
                            end
                        end
                    end
                end
                CMD_FREE: begin
                    if ((sel_map & slot_mask) == '0) begin
                        status_next = ST_DOUBLE_OR_ZERO;
                    end else begin
                        status_next = ST_OK;
                        for (int c = 0; c < NUM_CLASSES; c++) begin
                            if (cmd.cls == CLS_W'(c)) begin
                                map_next[c] = map_reg[c] & ~slot_mask;
                            end
                        end
                    end
                end
                default: begin
                    status_next = cmd.status;
                end
            endcase
        end
    end

    // Busy flag reflects the maps after this command.
    always_comb begin
        busy_next = busy_reg;
        if (cmd_pop) begin
            busy_next = 1'b0;
            for (int c = 0; c < NUM_CLASSES; c++) begin
                busy_next = busy_next | (|map_next[c]);
            end
        end
    end

    // Output register valid.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd_pop) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            for (int c = 0; c < NUM_CLASSES; c++) begin
                map_reg[c] <= '0;
            end
        end else begin
            out_valid_reg <= out_valid_next;
            map_reg       <= map_next;
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge aclk) begin
        offset_reg <= offset_next;
        status_reg <= status_next;
        busy_reg   <= busy_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_offset = offset_reg;
    assign out_status = status_reg;
    assign out_busy   = busy_reg;

endmodule

// ----- rtl/size_class_slot_allocator.sv -----
// Top level of the size-class slot allocator: size registers, classifier, queue, executor.
// Depends on scsa_pkg, scsa_front, scsa_cmd_fifo and scsa_back.
//
//   Channel   Direction  Ports                          Contents
//   request   in         s_tvalid s_tready s_tdata s_tuser  alloc or free request
//   result    out        m_tvalid m_tready m_tdata     offset, status, busy flag
//   config    in         cfg_we cfg_index cfg_wdata    slot size log2 per class
//
// Sustained rate is one request per cycle while m_tready stays high. A request transfer
// loads the queue; the executor then updates the map and loads the result register
// once that register is free or being drained, and m_tvalid rises with it.
// Reset (aresetn low, synchronous) frees every slot, loads sizes 3, 5, 7, 9 and
// empties the queue. A stalled result stage fills the two-entry queue before
// s_tready drops.
module size_class_slot_allocator
    import scsa_pkg::*;
#(
    parameter int NUM_CLASSES     = 4,
    parameter int SLOTS_PER_CLASS = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // request_bytes[12:0], release_offset[32:13], zero fill
    input  logic [S_TDATA_W-1:0] s_tdata,
    // action[0]
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // slot_offset[19:0], status[22:20], pool_busy[23]
    output logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 cfg_we,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [LG_W-1:0]      cfg_wdata
);

    logic [LG_W-1:0] cfg_reg [NUM_REGS];
    logic [LG_W-1:0] class_lg [NUM_CLASSES];

    cmd_t front_cmd;
    cmd_t queue_cmd;
    logic can_push;
    logic can_pop;
    logic cmd_pop;

    logic [OFFSET_W-1:0] res_offset;
    logic [STATUS_W-1:0] res_status;
    logic                res_busy;

    // Size registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                cfg_reg[i] <= CFG_RESET[i];
            end
        end else if (cfg_we) begin
            cfg_reg[cfg_index] <= cfg_wdata;
        end
    end

    // Effective size per class: extra classes share the last register, clamp at 4 KiB.
    for (genvar c = 0; c < NUM_CLASSES; c++) begin : g_lg
        localparam int R = (c < NUM_REGS) ? c : NUM_REGS - 1;
        assign class_lg[c] = (cfg_reg[R] > MAX_LG) ? MAX_LG : cfg_reg[R];
    end

    scsa_front #(
        .NUM_CLASSES     (NUM_CLASSES),
        .SLOTS_PER_CLASS (SLOTS_PER_CLASS)
    ) u_front (
        .action         (s_tuser),
        .request_bytes  (s_tdata[BYTES_W-1:0]),
        .release_offset (s_tdata[BYTES_W+OFFSET_W-1:BYTES_W]),
        .class_lg       (class_lg),
        .cmd            (front_cmd)
    );

    scsa_cmd_fifo u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (s_tvalid && can_push),
        .push_cmd (front_cmd),
        .can_push (can_push),
        .pop      (cmd_pop),
        .pop_cmd  (queue_cmd),
        .can_pop  (can_pop)
    );

    assign s_tready = can_push;

    scsa_back #(
        .NUM_CLASSES     (NUM_CLASSES),
        .SLOTS_PER_CLASS (SLOTS_PER_CLASS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd_valid  (can_pop),
        .cmd        (queue_cmd),
        .cmd_pop    (cmd_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_offset (res_offset),
        .out_status (res_status),
        .out_busy   (res_busy)
    );

    assign m_tdata = {res_busy, res_status, res_offset};

endmodule
